@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the scroll-refresh RTL.
// Included by the modules that check their own sequencing; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define WTSR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define WTSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/wtsr_pkg.sv @@
// Shared types and constants of the wrap-around tile scroll refresh block.
// Used by wtsr_divider, wtsr_sequencer and wrapped_tile_scroll_refresh.
package wtsr_pkg;

   // Field and register widths
   localparam int TILE_W     = 9;
   localparam int BUF_W      = 13;
   localparam int POS_W      = 20;
   localparam int STEP_W     = 16;
   localparam int IDX_W      = 12;
   localparam int SPLIT_W    = 13;
   localparam int KIND_W     = 2;
   localparam int DVD_W      = POS_W + 1;
   localparam int DVS_W      = BUF_W;
   localparam int CNT_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = POS_W;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 64;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COLUMN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ROW    = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_TILE_WIDTH    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_TILE_HEIGHT   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_BUFFER_WIDTH  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_BUFFER_HEIGHT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_MAP_COLUMNS   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_MAP_ROWS      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_LIMIT_X       = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_LIMIT_Y       = 3'd7;

   // Register reset values
   localparam logic [TILE_W-1:0] RST_TILE = 9'd16;
   localparam logic [BUF_W-1:0]  RST_BUF  = 13'd512;
   localparam logic [BUF_W-1:0]  RST_MAP  = 13'd64;
   localparam logic [POS_W-1:0]  RST_LIM  = 20'd0;

   typedef struct packed {
      logic [TILE_W-1:0] tile_width;
      logic [TILE_W-1:0] tile_height;
      logic [BUF_W-1:0]  buffer_width;
      logic [BUF_W-1:0]  buffer_height;
      logic [BUF_W-1:0]  map_columns;
      logic [BUF_W-1:0]  map_rows;
      logic [POS_W-1:0]  limit_x;
      logic [POS_W-1:0]  limit_y;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

endpackage

@@ rtl/core/wrapped_tile_scroll_refresh.sv @@
// Wrap-around tile scroll refresh, top level: configuration registers and port packing.
// Depends on wtsr_pkg, wtsr_divider and wtsr_sequencer.
//
// Usage: each req transaction carries one signed scroll step (x, y) in whole pixels.
// The block updates the view offset and the tile-aligned seam of the wrap-around
// buffer and answers on rsp with zero, one or two refresh commands (column first,
// then row) followed by one status item that has tlast set.
// Configuration registers are written through csr_we/csr_addr/csr_wdata; it is up to the
// user to write them only while no step is in flight, since nothing in the block enforces
// it. A write takes effect at the next clock edge. Each refresh costs five divisions on
// the shared 21-step divider; a forward seam move whose column or row lies past the map
// costs one division and gives no refresh. One step is worked on at a time; req_tready
// rises in the cycle after the status is loaded, and the next step can be taken while
// the last status item still waits in the output register.
// When the receiver stalls, the output register holds its item and the sequencer
// waits before loading the next one; nothing is dropped.
// Reset (synchronous, active high) returns the registers to their defaults and
// clears the view, the seam and the output register.

module wrapped_tile_scroll_refresh (
   input  logic                                clock,
   input  logic                                reset,
   // step_x [15:0], step_y [31:16]
   input  logic [wtsr_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // map_column [11:0], map_row [23:12], split_count [36:24], buffer_x [48:37],
   // buffer_y [60:49], moved [61], zero [63:62]
   output logic [wtsr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // kind [1:0]
   output logic [wtsr_pkg::KIND_W-1:0]         rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [wtsr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [wtsr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   wtsr_pkg::cfg_type                  cfg_ff, cfg_in;
   wtsr_pkg::div_req_type              div_req;
   wtsr_pkg::div_rsp_type              div_rsp;
   logic signed [wtsr_pkg::STEP_W-1:0] step_x, step_y;
   logic [wtsr_pkg::IDX_W-1:0]         map_column, map_row, buffer_x, buffer_y;
   logic [wtsr_pkg::SPLIT_W-1:0]       split_count;
   logic                               moved;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            wtsr_pkg::REG_TILE_WIDTH:    cfg_in.tile_width    = csr_wdata[wtsr_pkg::TILE_W-1:0];
            wtsr_pkg::REG_TILE_HEIGHT:   cfg_in.tile_height   = csr_wdata[wtsr_pkg::TILE_W-1:0];
            wtsr_pkg::REG_BUFFER_WIDTH:  cfg_in.buffer_width  = csr_wdata[wtsr_pkg::BUF_W-1:0];
            wtsr_pkg::REG_BUFFER_HEIGHT: cfg_in.buffer_height = csr_wdata[wtsr_pkg::BUF_W-1:0];
            wtsr_pkg::REG_MAP_COLUMNS:   cfg_in.map_columns   = csr_wdata[wtsr_pkg::BUF_W-1:0];
            wtsr_pkg::REG_MAP_ROWS:      cfg_in.map_rows      = csr_wdata[wtsr_pkg::BUF_W-1:0];
            wtsr_pkg::REG_LIMIT_X:       cfg_in.limit_x       = csr_wdata;
            wtsr_pkg::REG_LIMIT_Y:       cfg_in.limit_y       = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tile_width    <= wtsr_pkg::RST_TILE;
         cfg_ff.tile_height   <= wtsr_pkg::RST_TILE;
         cfg_ff.buffer_width  <= wtsr_pkg::RST_BUF;
         cfg_ff.buffer_height <= wtsr_pkg::RST_BUF;
         cfg_ff.map_columns   <= wtsr_pkg::RST_MAP;
         cfg_ff.map_rows      <= wtsr_pkg::RST_MAP;
         cfg_ff.limit_x       <= wtsr_pkg::RST_LIM;
         cfg_ff.limit_y       <= wtsr_pkg::RST_LIM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the step
   assign step_x = req_tdata[wtsr_pkg::STEP_W-1:0];
   assign step_y = req_tdata[2*wtsr_pkg::STEP_W-1:wtsr_pkg::STEP_W];

   wtsr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   wtsr_sequencer u_sequencer (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_step_x      (step_x),
      .req_step_y      (step_y),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_kind        (rsp_tuser),
      .rsp_map_column  (map_column),
      .rsp_map_row     (map_row),
      .rsp_split_count (split_count),
      .rsp_buffer_x    (buffer_x),
      .rsp_buffer_y    (buffer_y),
      .rsp_moved       (moved),
      .rsp_last        (rsp_tlast),
      .div_req         (div_req),
      .div_rsp         (div_rsp)
   );

   // Pack the result fields, lowest first
   assign rsp_tdata = {2'b00, moved, buffer_y, buffer_x, split_count, map_row, map_column};

endmodule

@@ rtl/core/wtsr_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on wtsr_pkg for widths and the request/response structs.
`include "assert_macros.svh"

module wtsr_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  wtsr_pkg::div_req_type div_req,
   output wtsr_pkg::div_rsp_type div_rsp
);

   localparam logic [wtsr_pkg::CNT_W-1:0] LAST_STEP = 5'(wtsr_pkg::DVD_W - 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [wtsr_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [wtsr_pkg::DVD_W-1:0]   quo_ff, quo_in;
   logic [wtsr_pkg::DVS_W-1:0]   rem_ff, rem_in;
   logic [wtsr_pkg::DVS_W-1:0]   dvs_ff, dvs_in;
   logic [wtsr_pkg::DVS_W:0]     trial;
   logic [wtsr_pkg::DVS_W:0]     diff;
   logic                         fits;

   // Trial subtract of the shifted partial remainder
   always_comb begin
      trial = {rem_ff, quo_ff[wtsr_pkg::DVD_W-1]};
      fits  = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};
   end

   // Load on start, then shift one quotient bit in per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[wtsr_pkg::DVD_W-2:0], fits};
         rem_in = fits ? diff[wtsr_pkg::DVS_W-1:0] : trial[wtsr_pkg::DVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

   `WTSR_ASSERT_IMPLY(a_start_idle, clock, reset, div_req.start, !busy_ff, "divider restarted while busy")
   `WTSR_ASSERT_IMPLY(a_done_at_end, clock, reset, $fell(busy_ff) && !$past(reset), done_ff, "divider finished without done")
   `WTSR_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "divider done held longer than one cycle")

endmodule

@@ rtl/core/wtsr_sequencer.sv @@
// Scroll sequencer: view and seam state, step checks, division schedule, result register.
// Depends on wtsr_pkg; drives the shared wtsr_divider through div_req/div_rsp.
`include "assert_macros.svh"

module wtsr_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  wtsr_pkg::cfg_type                  cfg,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic signed [wtsr_pkg::STEP_W-1:0] req_step_x,
   input  logic signed [wtsr_pkg::STEP_W-1:0] req_step_y,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wtsr_pkg::KIND_W-1:0]        rsp_kind,
   output logic [wtsr_pkg::IDX_W-1:0]         rsp_map_column,
   output logic [wtsr_pkg::IDX_W-1:0]         rsp_map_row,
   output logic [wtsr_pkg::SPLIT_W-1:0]       rsp_split_count,
   output logic [wtsr_pkg::IDX_W-1:0]         rsp_buffer_x,
   output logic [wtsr_pkg::IDX_W-1:0]         rsp_buffer_y,
   output logic                               rsp_moved,
   output logic                               rsp_last,
   output wtsr_pkg::div_req_type              div_req,
   input  wtsr_pkg::div_rsp_type              div_rsp
);

   // Sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_CHECK     = 4'd1;
   localparam logic [3:0] S_COL_DEC   = 4'd2;
   localparam logic [3:0] S_ROW_DEC   = 4'd3;
   localparam logic [3:0] S_LAUNCH    = 4'd4;
   localparam logic [3:0] S_DIV       = 4'd5;
   localparam logic [3:0] S_EMIT_COL  = 4'd6;
   localparam logic [3:0] S_EMIT_ROW  = 4'd7;
   localparam logic [3:0] S_EMIT_STAT = 4'd8;

   // Division operations
   localparam logic [3:0] OP_CFWD   = 4'd0;
   localparam logic [3:0] OP_CCOL   = 4'd1;
   localparam logic [3:0] OP_CBX    = 4'd2;
   localparam logic [3:0] OP_CBY    = 4'd3;
   localparam logic [3:0] OP_CROW0  = 4'd4;
   localparam logic [3:0] OP_CSPLIT = 4'd5;
   localparam logic [3:0] OP_RFWD   = 4'd6;
   localparam logic [3:0] OP_RROW   = 4'd7;
   localparam logic [3:0] OP_RBX    = 4'd8;
   localparam logic [3:0] OP_RBY    = 4'd9;
   localparam logic [3:0] OP_RCOL0  = 4'd10;
   localparam logic [3:0] OP_RSPLIT = 4'd11;

   localparam int PW = wtsr_pkg::POS_W;
   localparam int BW = wtsr_pkg::BUF_W;
   localparam int DW = wtsr_pkg::DVD_W;

   logic [3:0]                         state_ff, state_in;
   logic [3:0]                         op_ff, op_in;
   logic [PW-1:0]                      view_x_ff, view_x_in, view_y_ff, view_y_in;
   logic [PW-1:0]                      seam_x_ff, seam_x_in, seam_y_ff, seam_y_in;
   logic signed [wtsr_pkg::STEP_W-1:0] step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic                               moved_ff, moved_in;
   logic                               fwd_ff, fwd_in;
   logic [wtsr_pkg::IDX_W-1:0]         col_ff, col_in, row_ff, row_in;
   logic [wtsr_pkg::SPLIT_W-1:0]       split_ff, split_in;
   logic [BW-1:0]                      bx_ff, bx_in, by_ff, by_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [wtsr_pkg::KIND_W-1:0]        rsp_kind_ff, rsp_kind_in;
   logic [wtsr_pkg::IDX_W-1:0]         rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   logic [wtsr_pkg::SPLIT_W-1:0]       rsp_split_ff, rsp_split_in;
   logic [wtsr_pkg::IDX_W-1:0]         rsp_bx_ff, rsp_bx_in, rsp_by_ff, rsp_by_in;
   logic                               rsp_moved_ff, rsp_moved_in, rsp_last_ff, rsp_last_in;

   logic [BW-1:0]                      tw_nz, th_nz, bw_nz, bh_nz;
   logic [PW+1:0]                      nx, ny;
   logic                               refuse, clamp_x, clamp_y;
   logic                               out_free, load;
   logic                               quo_in_map_x, quo_in_map_y;
   logic [DW-1:0]                      dividend;
   logic [BW-1:0]                      divisor;

   // Zero-sized tiles and buffers count as one
   always_comb begin
      tw_nz = (cfg.tile_width == '0) ? BW'(1) : BW'(cfg.tile_width);
      th_nz = (cfg.tile_height == '0) ? BW'(1) : BW'(cfg.tile_height);
      bw_nz = (cfg.buffer_width == '0) ? BW'(1) : cfg.buffer_width;
      bh_nz = (cfg.buffer_height == '0) ? BW'(1) : cfg.buffer_height;
   end

   // Candidate view position and the refuse / clamp decisions
   always_comb begin
      nx      = {2'b00, view_x_ff} + (PW+2)'(step_x_ff);
      ny      = {2'b00, view_y_ff} + (PW+2)'(step_y_ff);
      refuse  = nx[PW+1] || ny[PW+1];
      clamp_x = nx[PW:0] > {1'b0, cfg.limit_x};
      clamp_y = ny[PW:0] > {1'b0, cfg.limit_y};
   end

   // Operand select for the shared divider
   always_comb begin
      case (op_ff)
         OP_CFWD: begin
            dividend = {1'b0, seam_x_ff} + DW'(bw_nz);
            divisor  = tw_nz;
         end
         OP_CCOL, OP_RCOL0: begin
            dividend = {1'b0, seam_x_ff};
            divisor  = tw_nz;
         end
         OP_CBX, OP_RBX: begin
            dividend = {1'b0, seam_x_ff};
            divisor  = bw_nz;
         end
         OP_CBY, OP_RBY: begin
            dividend = {1'b0, seam_y_ff};
            divisor  = bh_nz;
         end
         OP_CROW0, OP_RROW: begin
            dividend = {1'b0, seam_y_ff};
            divisor  = th_nz;
         end
         OP_CSPLIT: begin
            dividend = DW'(bh_nz - by_ff);
            divisor  = th_nz;
         end
         OP_RFWD: begin
            dividend = {1'b0, seam_y_ff} + DW'(bh_nz);
            divisor  = th_nz;
         end
         OP_RSPLIT: begin
            dividend = DW'(bw_nz - bx_ff);
            divisor  = tw_nz;
         end
         default: begin
            dividend = '0;
            divisor  = tw_nz;
         end
      endcase
   end

   assign div_req.start    = (state_ff == S_LAUNCH);
   assign div_req.dividend = dividend;
   assign div_req.divisor  = divisor;

   assign quo_in_map_x = div_rsp.quotient < DW'(cfg.map_columns);
   assign quo_in_map_y = div_rsp.quotient < DW'(cfg.map_rows);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load       = out_free && ((state_ff == S_EMIT_COL) || (state_ff == S_EMIT_ROW) ||
                                    (state_ff == S_EMIT_STAT));
   assign req_tready = (state_ff == S_IDLE);

   // Main sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      view_x_in = view_x_ff;
      view_y_in = view_y_ff;
      seam_x_in = seam_x_ff;
      seam_y_in = seam_y_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      moved_in  = moved_ff;
      fwd_in    = fwd_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      split_in  = split_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               step_x_in = req_step_x;
               step_y_in = req_step_y;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            moved_in = 1'b0;
            state_in = S_EMIT_STAT;
            if (refuse) begin
               // hold everything
            end else if (clamp_x) begin
               view_x_in = cfg.limit_x;
            end else if (clamp_y) begin
               view_y_in = cfg.limit_y;
            end else begin
               view_x_in = nx[PW-1:0];
               view_y_in = ny[PW-1:0];
               moved_in  = 1'b1;
               state_in  = S_COL_DEC;
            end
         end
         S_COL_DEC: begin
            if ({1'b0, view_x_ff} > ({1'b0, seam_x_ff} + (PW+1)'(cfg.tile_width))) begin
               fwd_in   = 1'b1;
               op_in    = OP_CFWD;
               state_in = S_LAUNCH;
            end else if (view_x_ff < seam_x_ff) begin
               // retreat the seam first, floored at zero
               seam_x_in = (seam_x_ff > PW'(cfg.tile_width)) ?
                           seam_x_ff - PW'(cfg.tile_width) : '0;
               fwd_in    = 1'b0;
               op_in     = OP_CCOL;
               state_in  = S_LAUNCH;
            end else begin
               state_in = S_ROW_DEC;
            end
         end
         S_ROW_DEC: begin
            if ({1'b0, view_y_ff} > ({1'b0, seam_y_ff} + (PW+1)'(cfg.tile_height))) begin
               fwd_in   = 1'b1;
               op_in    = OP_RFWD;
               state_in = S_LAUNCH;
            end else if (view_y_ff < seam_y_ff) begin
               seam_y_in = (seam_y_ff > PW'(cfg.tile_height)) ?
                           seam_y_ff - PW'(cfg.tile_height) : '0;
               fwd_in    = 1'b0;
               op_in     = OP_RROW;
               state_in  = S_LAUNCH;
            end else begin
               state_in = S_EMIT_STAT;
            end
         end
         S_LAUNCH: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_LAUNCH;
               case (op_ff)
                  OP_CFWD: begin
                     // drop the refresh when the new column lies past the map
                     if (quo_in_map_x) begin
                        col_in = div_rsp.quotient[wtsr_pkg::IDX_W-1:0];
                        op_in  = OP_CBX;
                     end else begin
                        state_in = S_ROW_DEC;
                     end
                  end
                  OP_CCOL: begin
                     col_in = div_rsp.quotient[wtsr_pkg::IDX_W-1:0];
                     op_in  = OP_CBX;
                  end
                  OP_CBX: begin
                     bx_in = div_rsp.remainder;
                     op_in = OP_CBY;
                  end
                  OP_CBY: begin
                     by_in = div_rsp.remainder;
                     op_in = OP_CROW0;
                  end
                  OP_CROW0: begin
                     row_in = div_rsp.quotient[wtsr_pkg::IDX_W-1:0];
                     op_in  = OP_CSPLIT;
                  end
                  OP_CSPLIT: begin
                     split_in = div_rsp.quotient[wtsr_pkg::SPLIT_W-1:0];
                     state_in = S_EMIT_COL;
                  end
                  OP_RFWD: begin
                     if (quo_in_map_y) begin
                        row_in = div_rsp.quotient[wtsr_pkg::IDX_W-1:0];
                        op_in  = OP_RBX;
                     end else begin
                        state_in = S_EMIT_STAT;
                     end
                  end
                  OP_RROW: begin
                     row_in = div_rsp.quotient[wtsr_pkg::IDX_W-1:0];
                     op_in  = OP_RBX;
                  end
                  OP_RBX: begin
                     bx_in = div_rsp.remainder;
                     op_in = OP_RBY;
                  end
                  OP_RBY: begin
                     by_in = div_rsp.remainder;
                     op_in = OP_RCOL0;
                  end
                  OP_RCOL0: begin
                     col_in = div_rsp.quotient[wtsr_pkg::IDX_W-1:0];
                     op_in  = OP_RSPLIT;
                  end
                  OP_RSPLIT: begin
                     split_in = div_rsp.quotient[wtsr_pkg::SPLIT_W-1:0];
                     state_in = S_EMIT_ROW;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_EMIT_COL: begin
            // advance the seam only after the refresh at the old seam is out
            if (out_free) begin
               if (fwd_ff) begin
                  seam_x_in = seam_x_ff + PW'(cfg.tile_width);
               end
               state_in = S_ROW_DEC;
            end
         end
         S_EMIT_ROW: begin
            if (out_free) begin
               if (fwd_ff) begin
                  seam_y_in = seam_y_ff + PW'(cfg.tile_height);
               end
               state_in = S_EMIT_STAT;
            end
         end
         S_EMIT_STAT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register payload
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_split_in = rsp_split_ff;
      rsp_bx_in    = rsp_bx_ff;
      rsp_by_in    = rsp_by_ff;
      rsp_moved_in = rsp_moved_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (state_ff == S_EMIT_STAT) begin
            rsp_kind_in  = wtsr_pkg::KIND_STATUS;
            rsp_col_in   = '0;
            rsp_row_in   = '0;
            rsp_split_in = '0;
            rsp_bx_in    = '0;
            rsp_by_in    = '0;
            rsp_moved_in = moved_ff;
            rsp_last_in  = 1'b1;
         end else begin
            rsp_kind_in  = (state_ff == S_EMIT_COL) ? wtsr_pkg::KIND_COLUMN :
                                                      wtsr_pkg::KIND_ROW;
            rsp_col_in   = col_ff;
            rsp_row_in   = row_ff;
            rsp_split_in = split_ff;
            rsp_bx_in    = bx_ff[wtsr_pkg::IDX_W-1:0];
            rsp_by_in    = by_ff[wtsr_pkg::IDX_W-1:0];
            rsp_moved_in = 1'b0;
            rsp_last_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         view_x_ff    <= '0;
         view_y_ff    <= '0;
         seam_x_ff    <= '0;
         seam_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         view_x_ff    <= view_x_in;
         view_y_ff    <= view_y_in;
         seam_x_ff    <= seam_x_in;
         seam_y_ff    <= seam_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      step_x_ff    <= step_x_in;
      step_y_ff    <= step_y_in;
      moved_ff     <= moved_in;
      fwd_ff       <= fwd_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      split_ff     <= split_in;
      bx_ff        <= bx_in;
      by_ff        <= by_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_split_ff <= rsp_split_in;
      rsp_bx_ff    <= rsp_bx_in;
      rsp_by_ff    <= rsp_by_in;
      rsp_moved_ff <= rsp_moved_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_map_column  = rsp_col_ff;
   assign rsp_map_row     = rsp_row_ff;
   assign rsp_split_count = rsp_split_ff;
   assign rsp_buffer_x    = rsp_bx_ff;
   assign rsp_buffer_y    = rsp_by_ff;
   assign rsp_moved       = rsp_moved_ff;
   assign rsp_last        = rsp_last_ff;

   `WTSR_ASSERT_IMPLY(a_last_is_status, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_kind_ff == wtsr_pkg::KIND_STATUS, "final transaction is not a status item")
   `WTSR_ASSERT_IMPLY(a_idle_div_free, clock, reset, state_ff == S_IDLE, !div_rsp.busy, "divider busy while sequencer idle")
   `WTSR_ASSERT_NEXT(a_launch_runs, clock, reset, state_ff == S_LAUNCH, (state_ff == S_DIV) && div_rsp.busy, "division launch did not start the divider")

endmodule
